// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the window hit test.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define AST_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("window hit test: invariant violated");

// Condition in one cycle implies a condition in the next.
`define AST_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("window hit test: sequence violated");

// Condition holds in the cycle after reset.
`define AST_RESET(label, post) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error("window hit test: reset state wrong");

`endif

// ----- design/pwht_pkg.sv -----
// Package for the polyline window hit test: shared types and constants.
// No dependencies; used by the front end, the back end and the top level.
`default_nettype none

package pwht_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int SEG_DEPTH_DEF   = 4;
  localparam int RES_DEPTH_DEF   = 2;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_XMIN = 2'd0,
    REG_YMIN = 2'd1,
    REG_XMAX = 2'd2,
    REG_YMAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic is_first;
    logic is_last;
    logic test_en;
  } seg_flags_t;

  localparam int FLAG_BITS = $bits(seg_flags_t);

endpackage

`default_nettype wire

// ----- design/pwht_queue.sv -----
// Small register queue used between front and back and for results.
// Depends on nothing; DEPTH must be at least 2.
`default_nettype none

module pwht_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/pwht_front.sv -----
// Front end: keeps the previous vertex and forms one segment request per vertex.
// Depends on pwht_pkg.
`default_nettype none

module pwht_front #(
  parameter int COORD_WIDTH = pwht_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         accept,
  input  wire logic signed [COORD_WIDTH-1:0]                vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]                vertex_y,
  input  wire logic                                         first_vertex,
  input  wire logic                                         last_vertex,
  output logic [4*COORD_WIDTH+pwht_pkg::FLAG_BITS-1:0]      seg
);

  import pwht_pkg::*;

  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;
  logic signed [COORD_WIDTH-1:0] x1;
  logic signed [COORD_WIDTH-1:0] y1;
  seg_flags_t                    flags;

  always_comb begin
    flags.is_first = first_vertex;
    flags.is_last  = last_vertex;
    flags.test_en  = !first_vertex || last_vertex;
    x1 = first_vertex ? vertex_x : prev_x;
    y1 = first_vertex ? vertex_y : prev_y;
  end

  assign seg = {flags, x1, y1, vertex_x, vertex_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (accept) begin
      prev_x <= vertex_x;
      prev_y <= vertex_y;
    end
  end

endmodule

`default_nettype wire

// ----- design/pwht_seg_test.sv -----
// Back end: pipelined segment/window test, window registers and the sticky hit.
// Depends on pwht_pkg.
`default_nettype none

module pwht_seg_test #(
  parameter int COORD_WIDTH = pwht_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       wr_en,
  input  wire logic [pwht_pkg::CFG_INDEX_WIDTH-1:0]       wr_index,
  input  wire logic [COORD_WIDTH-1:0]                     wr_data,
  input  wire logic                                       seg_valid,
  input  wire logic [4*COORD_WIDTH+pwht_pkg::FLAG_BITS-1:0] seg_data,
  output logic                                            seg_pop,
  input  wire logic                                       res_full,
  output logic                                            res_push,
  output logic                                            res_hit
);

  import pwht_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int D  = W + 1;
  localparam int H  = D / 2;
  localparam int PL = D + H + 1;
  localparam int PH = 2 * D - H;
  localparam int P  = 2 * D;
  localparam int C  = P + 1;

  logic signed [W-1:0] xmin, ymin, xmax, ymax;

  // stage 1: raw segment
  logic                v1;
  seg_flags_t          f1;
  logic signed [W-1:0] x1, y1, x2, y2;
  // stage 2: classification and multiplier operands
  logic                v2, pt2, miss2, axis2;
  seg_flags_t          f2;
  logic signed [D-1:0] ma [4];
  logic signed [D-1:0] mb [4];
  // stage 3: partial products
  logic                v3, pt3, miss3, axis3;
  seg_flags_t          f3;
  logic signed [PL-1:0] pl [4];
  logic signed [PH-1:0] ph [4];
  // stage 4: full products
  logic                v4, pt4, miss4, axis4;
  seg_flags_t          f4;
  logic signed [P-1:0] prod [4];
  // stage 5: cross product signs
  logic                v5, pt5, miss5, axis5, n0, n1, z0, z1;
  seg_flags_t          f5;

  logic                adv;
  logic                in1, in2, miss_c, axis_c, same_c;
  logic signed [D-1:0] dx, dy, ea, fa, eb, fb;
  logic signed [W-1:0] ax, bx;
  logic signed [C-1:0] cr [2];
  logic                seg_hit, acc, acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      xmin <= '0;
      ymin <= '0;
      xmax <= '0;
      ymax <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_XMIN: xmin <= wr_data;
        REG_YMIN: ymin <= wr_data;
        REG_XMAX: xmax <= wr_data;
        REG_YMAX: ymax <= wr_data;
        default:  xmin <= xmin;
      endcase
    end
  end

  assign adv     = !(v5 && f5.is_last && res_full);
  assign seg_pop = adv && seg_valid;

  always_comb begin
    in1 = (x1 >= xmin) && (x1 <= xmax) && (y1 >= ymin) && (y1 <= ymax);
    in2 = (x2 >= xmin) && (x2 <= xmax) && (y2 >= ymin) && (y2 <= ymax);
    miss_c = ((x1 < xmin) && (x2 < xmin)) || ((x1 > xmax) && (x2 > xmax)) ||
             ((y1 < ymin) && (y2 < ymin)) || ((y1 > ymax) && (y2 > ymax));
    dx = {x2[W-1], x2} - {x1[W-1], x1};
    dy = {y2[W-1], y2} - {y1[W-1], y1};
    axis_c = (dx == '0) || (dy == '0);
    same_c = (dx[D-1] == dy[D-1]);
    ax = same_c ? xmax : xmin;
    bx = same_c ? xmin : xmax;
    ea = {ymin[W-1], ymin} - {y1[W-1], y1};
    fa = {ax[W-1], ax} - {x1[W-1], x1};
    eb = {ymax[W-1], ymax} - {y1[W-1], y1};
    fb = {bx[W-1], bx} - {x1[W-1], x1};
  end

  always_comb begin
    cr[0] = $signed(prod[0]) - $signed(prod[1]);
    cr[1] = $signed(prod[2]) - $signed(prod[3]);
  end

  always_comb begin
    seg_hit  = pt5 || (!miss5 && (axis5 || z0 || z1 || (n0 != n1)));
    acc_next = (f5.is_first ? 1'b0 : acc) | (f5.test_en & seg_hit);
  end

  assign res_push = adv && v5 && f5.is_last;
  assign res_hit  = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      acc <= 1'b0;
    end else if (adv) begin
      v1 <= seg_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (v5) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {f1, x1, y1, x2, y2} <= seg_data;

      f2    <= f1;
      pt2   <= in1 || in2;
      miss2 <= miss_c;
      axis2 <= axis_c;
      ma[0] <= dx;
      mb[0] <= ea;
      ma[1] <= dy;
      mb[1] <= fa;
      ma[2] <= dx;
      mb[2] <= eb;
      ma[3] <= dy;
      mb[3] <= fb;

      f3    <= f2;
      pt3   <= pt2;
      miss3 <= miss2;
      axis3 <= axis2;
      for (int k = 0; k < 4; k++) begin
        pl[k] <= ma[k] * $signed({1'b0, mb[k][H-1:0]});
        ph[k] <= ma[k] * $signed(mb[k][D-1:H]);
      end

      f4    <= f3;
      pt4   <= pt3;
      miss4 <= miss3;
      axis4 <= axis3;
      for (int k = 0; k < 4; k++) begin
        prod[k] <= ($signed(ph[k]) <<< H) + $signed(pl[k]);
      end

      f5    <= f4;
      pt5   <= pt4;
      miss5 <= miss4;
      axis5 <= axis4;
      n0    <= cr[0][C-1];
      n1    <= cr[1][C-1];
      z0    <= (cr[0] == '0);
      z1    <= (cr[1] == '0);
    end
  end

endmodule

`default_nettype wire

// ----- design/polyline_window_hit_test.sv -----
// Polyline window hit test: top level joining front end, segment queue,
// back-end test pipeline and result queue. Depends on pwht_pkg and submodules.
//
// Vertices enter on the push/full channel with first/last marks; a vertex is
// taken when push is high and full is low. Each polyline yields one hit bit,
// offered on hit while empty is low and taken when pop is high.
// The user must write the window edges through wr_en/wr_index/wr_data only
// while idle; the block does not enforce it. Throughput: one vertex per
// cycle while full is low. The result of a last vertex passes the segment
// queue, the 5-stage test pipeline (segment register, compare, split
// products, product sum, cross-product sign) and the result queue to hit.
// Reset (synchronous) clears the window to zero, the previous vertex to the
// origin, the sticky hit and both queues.
// When pop stays low, up to 2 results wait in the result queue; after that
// the test pipeline holds, the 4-entry segment queue fills and full rises.
`default_nettype none

module polyline_window_hit_test #(
  parameter int COORD_WIDTH = pwht_pkg::COORD_WIDTH_DEF,
  parameter int SEG_DEPTH   = pwht_pkg::SEG_DEPTH_DEF,
  parameter int RES_DEPTH   = pwht_pkg::RES_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [COORD_WIDTH-1:0]        vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]        vertex_y,
  input  wire logic                                 first_vertex,
  input  wire logic                                 last_vertex,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic                                      hit,
  input  wire logic                                 wr_en,
  input  wire logic [pwht_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [COORD_WIDTH-1:0]               wr_data
);

  import pwht_pkg::*;

  localparam int SEG_WIDTH = 4 * COORD_WIDTH + FLAG_BITS;

  logic                 accept;
  logic [SEG_WIDTH-1:0] seg_in;
  logic [SEG_WIDTH-1:0] seg_out;
  logic                 seg_empty;
  logic                 seg_pop;
  logic                 res_full;
  logic                 res_push;
  logic                 res_hit;

  assign accept = push && !full;

  pwht_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .first_vertex(first_vertex),
    .last_vertex (last_vertex),
    .seg         (seg_in)
  );

  pwht_queue #(
    .WIDTH(SEG_WIDTH),
    .DEPTH(SEG_DEPTH)
  ) u_seg_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .din  (seg_in),
    .pop  (seg_pop),
    .dout (seg_out),
    .full (full),
    .empty(seg_empty)
  );

  pwht_seg_test #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_seg_test (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .seg_valid(!seg_empty),
    .seg_data (seg_out),
    .seg_pop  (seg_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_hit  (res_hit)
  );

  pwht_queue #(
    .WIDTH(1),
    .DEPTH(RES_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_hit),
    .pop  (pop),
    .dout (hit),
    .full (res_full),
    .empty(empty)
  );

endmodule

`default_nettype wire

// ----- design/pwht_checker.sv -----
// Port-level checker for the polyline window hit test, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pwht_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic last_vertex,
  input wire logic empty,
  input wire logic pop,
  input wire logic hit
);

  logic [4:0] pend;
  logic       in_last;
  logic       out_take;

  assign in_last  = push && !full && last_vertex;
  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {4'd0, in_last} - {4'd0, out_take};
    end
  end

  `AST_RESET(a_reset_clears, empty && !full)
  `AST_HOLDS(a_no_invented, empty || (pend != 5'd0))
  `AST_NEXT(a_result_held, !empty && !pop, !empty && $stable(hit))
  `AST_NEXT(a_full_needs_push, !(push && !full), !$rose(full))

endmodule

bind polyline_window_hit_test pwht_checker u_checker (.*);

`default_nettype wire
